/* rtl/clt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

  typedef enum logic [1:0] {
    MODE_NAME = 2'd0,
    MODE_GAP  = 2'd1,
    MODE_ARG  = 2'd2
  } clt_mode_e;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSL   = 8'h5c;

  localparam int unsigned TOTAL_W = 16;

endpackage

`default_nettype wire

/* rtl/clt_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* rtl/clt_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slash_count;
  logic        slash_overflow;
  logic        has_byte;
  logic [7:0]  out_byte;
  logic        end_arg;
  logic        end_line;
  logic [7:0]  arg_index;
  logic [15:0] char_total;

  modport source (
    output valid, output slash_count, output slash_overflow, output has_byte,
    output out_byte, output end_arg, output end_line, output arg_index,
    output char_total, input ready
  );
  modport sink (
    input valid, input slash_count, input slash_overflow, input has_byte,
    input out_byte, input end_arg, input end_line, input arg_index,
    input char_total, output ready
  );
endinterface

`default_nettype wire

/* rtl/command_line_tokenizer.sv */
// Command line tokenizer, Windows runtime argument splitting rules.
// in_i takes one line byte per word; a zero byte ends the line. out_o gives
// at most one word per input byte: a backslash count to emit, an optional
// argument character, argument and line end marks, the argument number and
// a saturating running total of bytes written.
// Each byte is decoded in the cycle it is accepted; its result sits in the
// output register in the next cycle. While out_o keeps up, one byte per cycle
// is sustained: in_i is ready whenever the output register is empty or is being
// drained, so the scan state and the single output register set the rate.
// Quotes in the program name, blanks between arguments, backslashes and plain
// quote toggles give no word.
// When out_o stalls with a word held, in_i drops ready until it is taken.
// Reset clears the scan state to program name mode and empties the output
// register. After the line end word the scan state returns to the same
// state, so the next byte begins a new line.
`timescale 1ns / 1ps
`default_nettype none

module command_line_tokenizer #(
  parameter int unsigned SLASH_MAX = 255,
  parameter int unsigned ARG_MAX   = 255
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  clt_in_if.sink     in_i,
  clt_out_if.source  out_o
);

  localparam int unsigned SW    = $clog2(SLASH_MAX + 1);
  localparam int unsigned AW    = $clog2(ARG_MAX + 1);
  localparam int unsigned ADDW  = SW + 1;
  localparam int unsigned SUMW  = ((ADDW > clt_pkg::TOTAL_W) ? ADDW : clt_pkg::TOTAL_W) + 1;
  localparam int unsigned EXTW  = 17;

  clt_pkg::clt_mode_e mode_q, mode_d;
  logic               inq_q, inq_d;
  logic               pend_q, pend_d;
  logic [SW-1:0]      run_q, run_d;
  logic               sat_q, sat_d;
  logic               odd_q, odd_d;
  logic [AW-1:0]      arg_q, arg_d;
  logic [15:0]        total_q, total_d;

  logic               ovalid_q;
  logic [7:0]         cnt8_q, byte_q, idx8_q;
  logic               ovf_q, has_q, earg_q, eline_q;
  logic [15:0]        otot_q;

  logic               in_acc;
  logic [7:0]         c;
  logic               is_blank;
  logic               emit, line_end;
  logic [SW-1:0]      cnt_o;
  logic               ovf_o, has_o, earg_o, eline_o;
  logic [AW-1:0]      idx_o;
  logic [ADDW-1:0]    add;
  logic [SUMW-1:0]    sum;
  logic [15:0]        tot_o;
  logic               e_inq, e_pend, e_sat, e_odd;
  logic [SW-1:0]      e_run, half;
  logic [AW-1:0]      e_arg, line_tot;
  logic [AW:0]        arg_inc;
  logic [EXTW-1:0]    cnt_ext, idx_ext;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign c          = in_i.in_byte;
  assign is_blank   = (c == clt_pkg::CHAR_SPACE) || (c == clt_pkg::CHAR_TAB);

  always_comb begin
    mode_d  = mode_q;
    inq_d   = inq_q;
    pend_d  = pend_q;
    run_d   = run_q;
    sat_d   = sat_q;
    odd_d   = odd_q;
    arg_d   = arg_q;
    emit    = 1'b0;
    line_end = 1'b0;
    cnt_o   = '0;
    ovf_o   = 1'b0;
    has_o   = 1'b0;
    earg_o  = 1'b0;
    eline_o = 1'b0;
    idx_o   = arg_q;
    add     = '0;
    e_inq   = inq_q;
    e_pend  = pend_q;
    e_run   = run_q;
    e_sat   = sat_q;
    e_odd   = odd_q;
    e_arg   = arg_q;
    half    = '0;
    arg_inc = '0;
    line_tot = '0;

    case (mode_q)
      clt_pkg::MODE_NAME: begin
        arg_inc  = (AW + 1)'(arg_q) + (AW + 1)'(1);
        line_tot = (arg_inc > (AW + 1)'(ARG_MAX)) ? AW'(ARG_MAX) : arg_inc[AW-1:0];
        if (c == clt_pkg::CHAR_QUOTE) begin
          inq_d = !inq_q;
        end else begin
          add  = ADDW'(1);
          emit = 1'b1;
          if (c == clt_pkg::CHAR_NUL) begin
            earg_o   = 1'b1;
            eline_o  = 1'b1;
            idx_o    = line_tot;
            line_end = 1'b1;
          end else if (is_blank && !inq_q) begin
            earg_o = 1'b1;
            inq_d  = 1'b0;
            mode_d = clt_pkg::MODE_GAP;
          end else begin
            has_o = 1'b1;
          end
        end
      end
      default: begin
        if (mode_q != clt_pkg::MODE_ARG) begin
          e_arg  = (arg_q < AW'(ARG_MAX)) ? arg_q + AW'(1) : arg_q;
          e_inq  = 1'b0;
          e_pend = 1'b0;
          e_run  = '0;
          e_sat  = 1'b0;
          e_odd  = 1'b0;
        end
        arg_inc  = (AW + 1)'(e_arg) + (AW + 1)'(1);
        line_tot = (arg_inc > (AW + 1)'(ARG_MAX)) ? AW'(ARG_MAX) : arg_inc[AW-1:0];
        idx_o    = e_arg;
        half     = e_run >> 1;
        if (mode_q != clt_pkg::MODE_ARG && is_blank) begin
          // stay between arguments
        end else if (mode_q != clt_pkg::MODE_ARG && c == clt_pkg::CHAR_NUL) begin
          emit     = 1'b1;
          eline_o  = 1'b1;
          idx_o    = AW'(((AW + 1)'(arg_q) + (AW + 1)'(1) > (AW + 1)'(ARG_MAX))
                         ? (AW + 1)'(ARG_MAX) : (AW + 1)'(arg_q) + (AW + 1)'(1));
          line_end = 1'b1;
        end else begin
          mode_d = clt_pkg::MODE_ARG;
          arg_d  = e_arg;
          inq_d  = e_inq;
          pend_d = 1'b0;
          run_d  = e_run;
          sat_d  = e_sat;
          odd_d  = e_odd;
          if (e_pend && c == clt_pkg::CHAR_QUOTE) begin
            add   = ADDW'(1);
            emit  = 1'b1;
            has_o = 1'b1;
          end else if (c == clt_pkg::CHAR_BSL) begin
            if (e_run < SW'(SLASH_MAX)) begin
              run_d = e_run + SW'(1);
            end else begin
              sat_d = 1'b1;
            end
            odd_d = !e_odd;
          end else begin
            run_d = '0;
            sat_d = 1'b0;
            odd_d = 1'b0;
            ovf_o = e_sat;
            if (c == clt_pkg::CHAR_QUOTE) begin
              cnt_o = half;
              if (e_odd) begin
                add   = ADDW'(half) + ADDW'(1);
                emit  = 1'b1;
                has_o = 1'b1;
              end else begin
                if (e_inq) begin
                  inq_d  = 1'b0;
                  pend_d = 1'b1;
                end else begin
                  inq_d = 1'b1;
                end
                if (half != '0 || e_sat) begin
                  add  = ADDW'(half);
                  emit = 1'b1;
                end
              end
            end else begin
              cnt_o = e_run;
              add   = ADDW'(e_run) + ADDW'(1);
              emit  = 1'b1;
              if (c == clt_pkg::CHAR_NUL) begin
                earg_o   = 1'b1;
                eline_o  = 1'b1;
                idx_o    = line_tot;
                line_end = 1'b1;
              end else if (is_blank && !e_inq) begin
                earg_o = 1'b1;
                mode_d = clt_pkg::MODE_GAP;
              end else begin
                has_o = 1'b1;
              end
            end
          end
        end
      end
    endcase

    sum   = SUMW'(total_q) + SUMW'(add);
    tot_o = (sum > SUMW'(16'hffff)) ? 16'hffff : sum[15:0];
    total_d = tot_o;

    if (line_end) begin
      mode_d  = clt_pkg::MODE_NAME;
      inq_d   = 1'b0;
      pend_d  = 1'b0;
      run_d   = '0;
      sat_d   = 1'b0;
      odd_d   = 1'b0;
      arg_d   = '0;
      total_d = '0;
    end
  end

  assign cnt_ext = EXTW'(cnt_o);
  assign idx_ext = EXTW'(idx_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= clt_pkg::MODE_NAME;
      inq_q    <= 1'b0;
      pend_q   <= 1'b0;
      run_q    <= '0;
      sat_q    <= 1'b0;
      odd_q    <= 1'b0;
      arg_q    <= '0;
      total_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_q  <= mode_d;
        inq_q   <= inq_d;
        pend_q  <= pend_d;
        run_q   <= run_d;
        sat_q   <= sat_d;
        odd_q   <= odd_d;
        arg_q   <= arg_d;
        total_q <= total_d;
      end
      if (in_acc && emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      cnt8_q  <= cnt_ext[7:0];
      ovf_q   <= ovf_o;
      has_q   <= has_o;
      byte_q  <= has_o ? c : 8'h00;
      earg_q  <= earg_o;
      eline_q <= eline_o;
      idx8_q  <= idx_ext[7:0];
      otot_q  <= tot_o;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.slash_count    = cnt8_q;
  assign out_o.slash_overflow = ovf_q;
  assign out_o.has_byte       = has_q;
  assign out_o.out_byte       = byte_q;
  assign out_o.end_arg        = earg_q;
  assign out_o.end_line       = eline_q;
  assign out_o.arg_index      = idx8_q;
  assign out_o.char_total     = otot_q;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SLASH_MAX = 255;
  localparam int unsigned ARG_MAX   = 255;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_COUNT = 1900;
  localparam int unsigned IDLE_PCT = 11;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0]  slash_count;
    logic        slash_overflow;
    logic        has_byte;
    logic [7:0]  out_byte;
    logic        end_arg;
    logic        end_line;
    logic [7:0]  arg_index;
    logic [15:0] char_total;
  } lex_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  clt_in_if  in_if ();
  clt_out_if out_if ();

  command_line_tokenizer #(
    .SLASH_MAX(SLASH_MAX),
    .ARG_MAX  (ARG_MAX)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #4 clk = ~clk;

  logic [7:0]  line_bytes[$];
  lex_word_t   expected_words[$];
  int unsigned cycle_count = 0;
  int unsigned errors = 0;

  clt_pkg::clt_mode_e scan_state = clt_pkg::MODE_NAME;
  bit          quoted = 1'b0;
  bit          quote_pend = 1'b0;
  int unsigned bsl_run = 0;
  bit          bsl_sat = 1'b0;
  bit          bsl_odd = 1'b0;
  int unsigned arg_num = 0;
  int unsigned bytes_written = 0;

  function automatic void clear_line();
    scan_state = clt_pkg::MODE_NAME;
    quoted = 1'b0;
    quote_pend = 1'b0;
    bsl_run = 0;
    bsl_sat = 1'b0;
    bsl_odd = 1'b0;
    arg_num = 0;
    bytes_written = 0;
  endfunction

  function automatic void bump_total(int unsigned n);
    bytes_written = (bytes_written + n > 65535) ? 65535 : bytes_written + n;
  endfunction

  function automatic int unsigned arg_total();
    return (arg_num + 1 > ARG_MAX) ? ARG_MAX : arg_num + 1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == clt_pkg::CHAR_SPACE || c == clt_pkg::CHAR_TAB;
  endfunction

  function automatic lex_word_t make_word(int unsigned cnt, bit ovf, bit has,
                                          logic [7:0] b, bit ea, bit el,
                                          int unsigned idx);
    lex_word_t w;
    w.slash_count    = 8'(cnt);
    w.slash_overflow = ovf;
    w.has_byte       = has;
    w.out_byte       = has ? b : 8'h00;
    w.end_arg        = ea;
    w.end_line       = el;
    w.arg_index      = 8'(idx);
    w.char_total     = 16'(bytes_written);
    return w;
  endfunction

  function automatic bit tokenize_byte(input logic [7:0] c, output lex_word_t w);
    int unsigned cnt;
    int unsigned half;
    bit ovf;
    bit odd;
    w = '0;
    if (scan_state == clt_pkg::MODE_NAME) begin
      if (c == clt_pkg::CHAR_QUOTE) begin
        quoted = !quoted;
        return 1'b0;
      end
      bump_total(1);
      if (c == clt_pkg::CHAR_NUL) begin
        w = make_word(0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, arg_total());
        clear_line();
        return 1'b1;
      end
      if (is_blank(c) && !quoted) begin
        w = make_word(0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, arg_num);
        quoted = 1'b0;
        scan_state = clt_pkg::MODE_GAP;
        return 1'b1;
      end
      w = make_word(0, 1'b0, 1'b1, c, 1'b0, 1'b0, arg_num);
      return 1'b1;
    end
    if (scan_state != clt_pkg::MODE_ARG) begin
      if (is_blank(c)) return 1'b0;
      if (c == clt_pkg::CHAR_NUL) begin
        w = make_word(0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, arg_total());
        clear_line();
        return 1'b1;
      end
      if (arg_num < ARG_MAX) arg_num++;
      scan_state = clt_pkg::MODE_ARG;
      quoted = 1'b0;
      quote_pend = 1'b0;
      bsl_run = 0;
      bsl_sat = 1'b0;
      bsl_odd = 1'b0;
    end
    if (quote_pend) begin
      quote_pend = 1'b0;
      if (c == clt_pkg::CHAR_QUOTE) begin
        bump_total(1);
        w = make_word(0, 1'b0, 1'b1, c, 1'b0, 1'b0, arg_num);
        return 1'b1;
      end
    end
    if (c == clt_pkg::CHAR_BSL) begin
      if (bsl_run < SLASH_MAX) bsl_run++;
      else bsl_sat = 1'b1;
      bsl_odd = !bsl_odd;
      return 1'b0;
    end
    cnt = bsl_run;
    ovf = bsl_sat;
    odd = bsl_odd;
    bsl_run = 0;
    bsl_sat = 1'b0;
    bsl_odd = 1'b0;
    if (c == clt_pkg::CHAR_QUOTE) begin
      half = cnt / 2;
      if (odd) begin
        bump_total(half + 1);
        w = make_word(half, ovf, 1'b1, c, 1'b0, 1'b0, arg_num);
        return 1'b1;
      end
      if (quoted) begin
        quoted = 1'b0;
        quote_pend = 1'b1;
      end else begin
        quoted = 1'b1;
      end
      if (half == 0 && !ovf) return 1'b0;
      bump_total(half);
      w = make_word(half, ovf, 1'b0, 8'h00, 1'b0, 1'b0, arg_num);
      return 1'b1;
    end
    bump_total(cnt + 1);
    if (c == clt_pkg::CHAR_NUL) begin
      w = make_word(cnt, ovf, 1'b0, 8'h00, 1'b1, 1'b1, arg_total());
      clear_line();
      return 1'b1;
    end
    if (is_blank(c) && !quoted) begin
      w = make_word(cnt, ovf, 1'b0, 8'h00, 1'b1, 1'b0, arg_num);
      scan_state = clt_pkg::MODE_GAP;
      return 1'b1;
    end
    w = make_word(cnt, ovf, 1'b1, c, 1'b0, 1'b0, arg_num);
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 1) == 0) ? clt_pkg::CHAR_SPACE : clt_pkg::CHAR_TAB;
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(8'(s[i]));
  endtask

  task automatic push_run(input logic [7:0] b, input int unsigned n);
    repeat (n) line_bytes.push_back(b);
  endtask

  task automatic push_blanks(input int unsigned n);
    repeat (n) line_bytes.push_back(rand_blank());
  endtask

  task automatic add_random_line();
    int unsigned n_tok;
    int unsigned n_args;
    int unsigned r;
    if ($urandom_range(0, 9) == 0) begin
      n_tok = $urandom_range(1, 12);
      repeat (n_tok) line_bytes.push_back(8'($urandom_range(0, 255)));
      line_bytes.push_back(clt_pkg::CHAR_NUL);
      return;
    end
    n_tok = $urandom_range(0, 6);
    repeat (n_tok) begin
      r = $urandom_range(0, 99);
      if (r < 15) line_bytes.push_back(clt_pkg::CHAR_QUOTE);
      else if (r < 25) line_bytes.push_back(rand_blank());
      else if (r < 40) line_bytes.push_back(8'($urandom_range(1, 255)));
      else line_bytes.push_back(rand_letter());
    end
    n_args = $urandom_range(0, 4);
    repeat (n_args) begin
      push_blanks($urandom_range(1, 3));
      n_tok = $urandom_range(1, 6);
      repeat (n_tok) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          line_bytes.push_back(rand_letter());
        end else if (r < 40) begin
          line_bytes.push_back(8'($urandom_range(1, 255)));
        end else if (r < 60) begin
          push_run(clt_pkg::CHAR_BSL, $urandom_range(0, 5));
          line_bytes.push_back(clt_pkg::CHAR_QUOTE);
        end else if (r < 70) begin
          line_bytes.push_back(clt_pkg::CHAR_QUOTE);
        end else if (r < 80) begin
          push_run(clt_pkg::CHAR_BSL, $urandom_range(1, 3));
          line_bytes.push_back(rand_letter());
        end else if (r < 90) begin
          push_run(clt_pkg::CHAR_QUOTE, 2);
        end else begin
          line_bytes.push_back(rand_blank());
        end
      end
    end
    if ($urandom_range(0, 3) == 0) push_blanks($urandom_range(1, 2));
    if ($urandom_range(0, 3) == 0) push_run(clt_pkg::CHAR_BSL, $urandom_range(1, 3));
    line_bytes.push_back(clt_pkg::CHAR_NUL);
  endtask

  // no idling on either side through this window
  function automatic bit take_idle();
    if (cycle_count >= 4000 && cycle_count < 9000) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  always @(posedge clk or negedge rst_n) begin
    lex_word_t w;
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (tokenize_byte(in_if.in_byte, w)) expected_words.push_back(w);
      end
      if (!in_if.valid || in_if.ready) begin
        if (line_bytes.size() != 0 && !take_idle()) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= line_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    lex_word_t got;
    lex_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.slash_count, out_if.slash_overflow, out_if.has_byte,
               out_if.out_byte, out_if.end_arg, out_if.end_line,
               out_if.arg_index, out_if.char_total};
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("extra cnt=%0d ovf=%0d has=%0d byte=%h ea=%0d el=%0d idx=%0d tot=%0d",
                     got.slash_count, got.slash_overflow, got.has_byte, got.out_byte,
                     got.end_arg, got.end_line, got.arg_index, got.char_total);
        end else begin
          want = expected_words.pop_front();
          if (got.slash_count !== want.slash_count ||
              got.slash_overflow !== want.slash_overflow ||
              got.has_byte !== want.has_byte || got.out_byte !== want.out_byte ||
              got.end_arg !== want.end_arg || got.end_line !== want.end_line ||
              got.arg_index !== want.arg_index || got.char_total !== want.char_total) begin
            errors++;
            if (errors <= 10) begin
              $display("exp cnt=%0d ovf=%0d has=%0d byte=%h ea=%0d el=%0d idx=%0d tot=%0d",
                       want.slash_count, want.slash_overflow, want.has_byte, want.out_byte,
                       want.end_arg, want.end_line, want.arg_index, want.char_total);
              $display("got cnt=%0d ovf=%0d has=%0d byte=%h ea=%0d el=%0d idx=%0d tot=%0d",
                       got.slash_count, got.slash_overflow, got.has_byte, got.out_byte,
                       got.end_arg, got.end_line, got.arg_index, got.char_total);
            end
          end
        end
      end
      out_if.ready <= !take_idle();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[command_line_tokenizer] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned line_no;

    line_bytes.push_back(clt_pkg::CHAR_NUL);
    push_text("\"p q\"r\t \\\\\\\"x\\\\\"y\"\"\"z ");
    line_bytes.push_back(clt_pkg::CHAR_NUL);
    push_text("a\t\"b\"c");
    line_bytes.push_back(8'hff);
    line_bytes.push_back(clt_pkg::CHAR_BSL);
    line_bytes.push_back(clt_pkg::CHAR_NUL);

    line_no = 0;
    while (line_bytes.size() < ITEM_COUNT) begin
      line_no++;
      if (line_no == 10) begin
        // backslash runs at and past the counter limit
        push_text("s ");
        push_run(clt_pkg::CHAR_BSL, SLASH_MAX);
        line_bytes.push_back(rand_letter());
        line_bytes.push_back(clt_pkg::CHAR_SPACE);
        push_run(clt_pkg::CHAR_BSL, SLASH_MAX + 1 + 2 * $urandom_range(0, 3));
        line_bytes.push_back(clt_pkg::CHAR_QUOTE);
        line_bytes.push_back(rand_letter());
        push_run(clt_pkg::CHAR_BSL, SLASH_MAX + 2 + 2 * $urandom_range(0, 3));
        line_bytes.push_back(clt_pkg::CHAR_QUOTE);
        push_run(clt_pkg::CHAR_BSL, SLASH_MAX + $urandom_range(1, 40));
        line_bytes.push_back(clt_pkg::CHAR_NUL);
      end else if (line_no == 20) begin
        // argument number past its limit
        push_text("m");
        repeat (ARG_MAX + $urandom_range(1, 40)) begin
          line_bytes.push_back(rand_blank());
          line_bytes.push_back(rand_letter());
        end
        line_bytes.push_back(clt_pkg::CHAR_NUL);
      end else begin
        add_random_line();
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (line_bytes.size() != 0 || in_if.valid) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("[command_line_tokenizer] OK");
    end else begin
      $display("[command_line_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
